@@ rtl/core/color_matrix_pixel_top_defines.svh @@
// Assertion macros shared by the color matrix pixel RTL.
// Included by modules that carry concurrent checks; needs no other file.
`ifndef COLOR_MATRIX_PIXEL_TOP_DEFINES_SVH
`define COLOR_MATRIX_PIXEL_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// check that is switched off while reset is asserted
`define CMP_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");

// check that must also hold during reset
`define CMP_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("%m: check failed");

`else

`define CMP_ASSERT(name, clk, rst_n, prop)
`define CMP_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

@@ rtl/core/cmp_pkg.sv @@
// Types, widths and register codes of the color matrix pixel block.
// Used by every module in rtl/core; depends on nothing.
package cmp_pkg;

  localparam int unsigned NumRegs = 8;
  localparam int unsigned ChanW   = 16;
  localparam int unsigned CoefW   = 24;
  localparam int unsigned TermW   = 24;
  localparam int unsigned SumW    = 26;
  localparam int unsigned RegW    = 48;
  localparam int unsigned CfgW    = 49;
  localparam int unsigned ModeBit = 48;

  typedef logic [ChanW-1:0]        chan_t;
  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [TermW-1:0] term_t;
  typedef logic signed [SumW-1:0]  sum_t;
  typedef logic [RegW-1:0]         cfg_reg_t;

  // red sits in the lowest bits
  typedef struct packed {
    chan_t alpha;
    chan_t blue;
    chan_t green;
    chan_t red;
  } pixel_t;

  // [row][column], row = output channel, column = input channel
  typedef coef_t [3:0][3:0] coef_mat_t;
  typedef term_t [3:0][3:0] term_mat_t;
  typedef sum_t  [3:0]      sum_vec_t;

  typedef enum logic [2:0] {
    RegRow0Cols01 = 3'd0,
    RegRow0Cols23 = 3'd1,
    RegRow1Cols01 = 3'd2,
    RegRow1Cols23 = 3'd3,
    RegRow2Cols01 = 3'd4,
    RegRow2Cols23 = 3'd5,
    RegRow3Cols01 = 3'd6,
    RegRow3Cols23 = 3'd7
  } reg_idx_e;

  // identity matrix after reset
  localparam cfg_reg_t RegReset [NumRegs] = '{
    48'd65536, 48'd0, 48'd1099511627776, 48'd0,
    48'd0, 48'd65536, 48'd0, 48'd1099511627776
  };

endpackage

@@ rtl/core/cmp_mult.sv @@
// Stage one: sixteen coefficient-by-channel products, each floored by 2^16.
// Depends on cmp_pkg.
module cmp_mult (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cmp_pkg::pixel_t    in_pix_i,
  input  cmp_pkg::coef_mat_t coef_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cmp_pkg::term_mat_t out_term_o
);

  localparam int unsigned ProdW = cmp_pkg::CoefW + cmp_pkg::ChanW + 1;

  cmp_pkg::chan_t     ch [4];
  logic signed [ProdW-1:0] prod [4][4];
  cmp_pkg::term_mat_t term_d, term_q;
  logic valid_q;
  logic adv;

  assign ch[0] = in_pix_i.red;
  assign ch[1] = in_pix_i.green;
  assign ch[2] = in_pix_i.blue;
  assign ch[3] = in_pix_i.alpha;

  // signed coefficient times zero-extended channel, arithmetic shift by 16
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        prod[r][c] = $signed(coef_i[r][c]) * $signed({1'b0, ch[c]});
        term_d[r][c] = prod[r][c][cmp_pkg::TermW+15:16];
      end
    end
  end

  assign adv        = !valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      term_q <= term_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_term_o  = term_q;

endmodule

@@ rtl/core/cmp_sum.sv @@
// Stage two: adds the four terms of each matrix row into a 26-bit sum.
// Depends on cmp_pkg.
module cmp_sum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cmp_pkg::term_mat_t in_term_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cmp_pkg::sum_vec_t  out_sum_o
);

  localparam int unsigned ExtW = cmp_pkg::SumW - cmp_pkg::TermW;

  cmp_pkg::sum_vec_t sum_d, sum_q;
  logic valid_q;
  logic adv;

  // sign-extend each term and add the row
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum_d[r] = '0;
      for (int c = 0; c < 4; c++) begin
        sum_d[r] = sum_d[r]
                 + {{ExtW{in_term_i[r][c][cmp_pkg::TermW-1]}}, in_term_i[r][c]};
      end
    end
  end

  assign adv        = !valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      sum_q <= sum_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_sum_o   = sum_q;

endmodule

@@ rtl/core/cmp_clamp.sv @@
// Stage three: clamps alpha, then the colors to 0..65535 or 0..alpha; output register.
// Depends on cmp_pkg and color_matrix_pixel_top_defines.svh.
`include "color_matrix_pixel_top_defines.svh"

module cmp_clamp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              premult_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cmp_pkg::sum_vec_t in_sum_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cmp_pkg::pixel_t   out_pix_o
);

  localparam int unsigned ChanW = cmp_pkg::ChanW;
  localparam int unsigned SumW  = cmp_pkg::SumW;

  cmp_pkg::chan_t  alpha_c, hi_c;
  cmp_pkg::chan_t  col_c [3];
  cmp_pkg::sum_t   v;
  cmp_pkg::pixel_t pix_d, pix_q;
  logic valid_q, mode_q;
  logic adv;

  // alpha first, it bounds the colors in premultiplied mode
  always_comb begin
    v = '0;
    if (in_sum_i[3][SumW-1]) begin
      alpha_c = '0;
    end else if (|in_sum_i[3][SumW-2:ChanW]) begin
      alpha_c = '1;
    end else begin
      alpha_c = in_sum_i[3][ChanW-1:0];
    end
    hi_c = premult_i ? alpha_c : '1;
    for (int r = 0; r < 3; r++) begin
      v = in_sum_i[r];
      if (v[SumW-1]) begin
        col_c[r] = '0;
      end else if ((|v[SumW-2:ChanW]) || (v[ChanW-1:0] > hi_c)) begin
        col_c[r] = hi_c;
      end else begin
        col_c[r] = v[ChanW-1:0];
      end
    end
    pix_d.red   = col_c[0];
    pix_d.green = col_c[1];
    pix_d.blue  = col_c[2];
    pix_d.alpha = alpha_c;
  end

  assign adv        = !valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= in_valid_i;
    end
  end

  // mode travels with the beat so checks see the clamp actually applied
  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      pix_q  <= pix_d;
      mode_q <= premult_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_pix_o   = pix_q;

  `CMP_ASSERT(a_premult_bound, clk_i, rst_ni,
    valid_q && mode_q |-> (pix_q.red <= pix_q.alpha) && (pix_q.green <= pix_q.alpha)
                          && (pix_q.blue <= pix_q.alpha))

endmodule

@@ rtl/core/color_matrix_pixel_top.sv @@
// Input beat to output beat passes the multiply, row sum and clamp registers in turn.
// Throughput: one pixel per cycle unless the sink stalls; each stage holds one beat, set by its register.
// Backpressure stalls only full stages; bubbles are squeezed out.
// Reset: async active low; pipeline empties, matrix returns to identity, straight clamp.
// Top level of the color matrix pixel block: config registers and three-stage pipeline.
// Depends on cmp_pkg, cmp_mult, cmp_sum, cmp_clamp and the defines header.
`include "color_matrix_pixel_top_defines.svh"

module color_matrix_pixel_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [48:0] cfg_wdata_i,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // in_red[15:0], in_green[31:16], in_blue[47:32], in_alpha[63:48]
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // out_red[15:0], out_green[31:16], out_blue[47:32], out_alpha[63:48]
);

  cmp_pkg::cfg_reg_t  cfg_q [cmp_pkg::NumRegs];
  logic               mode_q;
  cmp_pkg::coef_mat_t coef;
  cmp_pkg::pixel_t    in_pix, out_pix;
  cmp_pkg::term_mat_t term;
  cmp_pkg::sum_vec_t  sum;
  logic mult_valid, mult_ready, sum_valid, sum_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cmp_pkg::NumRegs; i++) begin
        cfg_q[i] <= cmp_pkg::RegReset[i];
      end
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_wdata_i[cmp_pkg::RegW-1:0];
      if (cmp_pkg::reg_idx_e'(cfg_idx_i) == cmp_pkg::RegRow0Cols01) begin
        mode_q <= cfg_wdata_i[cmp_pkg::ModeBit];
      end
    end
  end

  // two coefficients per register, low half is the even column
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        coef[r][c] = cfg_q[3'(r * 2 + c / 2)][(c % 2) * cmp_pkg::CoefW +: cmp_pkg::CoefW];
      end
    end
  end

  assign in_pix = cmp_pkg::pixel_t'(s_tdata);

  cmp_mult u_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid),
    .in_ready_o  (s_tready),
    .in_pix_i    (in_pix),
    .coef_i      (coef),
    .out_valid_o (mult_valid),
    .out_ready_i (mult_ready),
    .out_term_o  (term)
  );

  cmp_sum u_sum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mult_valid),
    .in_ready_o  (mult_ready),
    .in_term_i   (term),
    .out_valid_o (sum_valid),
    .out_ready_i (sum_ready),
    .out_sum_o   (sum)
  );

  cmp_clamp u_clamp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .premult_i   (mode_q),
    .in_valid_i  (sum_valid),
    .in_ready_o  (sum_ready),
    .in_sum_i    (sum),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .out_pix_o   (out_pix)
  );

  assign m_tdata = out_pix;

  // input only stalls when every stage is full and the sink holds off
  `CMP_ASSERT_ALWAYS(a_stall_only_when_full, clk_i,
    !s_tready |-> m_tvalid && !m_tready && mult_valid && sum_valid)

  // with the sink ready, an accepted beat passes the multiply, sum and clamp registers and shows up on the output
  `CMP_ASSERT(a_flow_latency, clk_i, rst_ni,
    (s_tvalid && s_tready) ##1 m_tready ##1 m_tready |=> m_tvalid)

endmodule

@@ dv/color_matrix_pixel_top_tb.sv @@
// Testbench for color_matrix_pixel_top. It streams pixel beats through the 4x4 color
// matrix under several coefficient and clamp settings and scores every output beat.
// Depends on cmp_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module color_matrix_pixel_top_tb;

  localparam int unsigned RandPhases = 10;
  localparam int unsigned PhaseBeats = 125;
  localparam int unsigned ChanMax    = 65535;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     cfg_we_i    = 1'b0;
  logic [2:0]               cfg_idx_i   = '0;
  logic [cmp_pkg::CfgW-1:0] cfg_wdata_i = '0;
  logic                     s_tvalid    = 1'b0;
  logic                     s_tready;
  logic [63:0]              s_tdata     = '0;  // red[15:0], green[31:16], blue[47:32], alpha[63:48]
  logic                     m_tvalid;
  logic                     m_tready    = 1'b0;
  logic [63:0]              m_tdata;           // red[15:0], green[31:16], blue[47:32], alpha[63:48]
  bit                       no_idle     = 1'b0;

  // Shadow of the matrix registers plus the pixels still owed by the block
  class color_xform_model;
    logic [cmp_pkg::CfgW-1:0] regs_q [cmp_pkg::NumRegs];
    cmp_pkg::pixel_t          expected_pixels [$];
    int                       mismatch_count;

    function new();
      mismatch_count = 0;
      for (int i = 0; i < cmp_pkg::NumRegs; i++) regs_q[i] = {1'b0, cmp_pkg::RegReset[i]};
    endfunction

    // bits above a register's width are dropped, but register 0 keeps bit 48, the mode bit
    function void write_reg(cmp_pkg::reg_idx_e idx, logic [cmp_pkg::CfgW-1:0] data);
      if (idx == cmp_pkg::RegRow0Cols01) regs_q[idx] = data;
      else regs_q[idx] = {1'b0, data[cmp_pkg::RegW-1:0]};
    endfunction

    function longint coef(int r, int c);
      logic [cmp_pkg::CfgW-1:0] word;
      cmp_pkg::coef_t           k;
      word = regs_q[r*2 + c/2];
      k = (c % 2) ? word[2*cmp_pkg::CoefW-1:cmp_pkg::CoefW] : word[cmp_pkg::CoefW-1:0];
      return k;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // each term is floored by the arithmetic shift before the row sum
    function cmp_pkg::pixel_t transform_pixel(cmp_pkg::pixel_t px);
      longint chan [4];
      longint acc [4];
      longint alpha;
      longint ceiling;
      cmp_pkg::pixel_t res;
      chan[0] = px.red;
      chan[1] = px.green;
      chan[2] = px.blue;
      chan[3] = px.alpha;
      for (int r = 0; r < 4; r++) begin
        acc[r] = 0;
        for (int c = 0; c < 4; c++) acc[r] += (coef(r, c) * chan[c]) >>> 16;
      end
      alpha   = clamp(acc[3], 0, ChanMax);
      ceiling = regs_q[cmp_pkg::RegRow0Cols01][cmp_pkg::ModeBit] ? alpha : ChanMax;
      res.red   = cmp_pkg::chan_t'(clamp(acc[0], 0, ceiling));
      res.green = cmp_pkg::chan_t'(clamp(acc[1], 0, ceiling));
      res.blue  = cmp_pkg::chan_t'(clamp(acc[2], 0, ceiling));
      res.alpha = cmp_pkg::chan_t'(alpha);
      return res;
    endfunction

    function void note_pixel(cmp_pkg::pixel_t px);
      expected_pixels.push_back(transform_pixel(px));
    endfunction

    function void check_pixel(cmp_pkg::pixel_t got);
      cmp_pkg::pixel_t want;
      if (expected_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("ERROR: output beat %h with no pixel owed", got);
        return;
      end
      want = expected_pixels.pop_front();
      if (got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.alpha !== want.alpha) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: rgba expected %h %h %h %h, got %h %h %h %h",
                   want.red, want.green, want.blue, want.alpha,
                   got.red, got.green, got.blue, got.alpha);
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  color_xform_model xform = new();

  color_matrix_pixel_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  always #2 clk_i = ~clk_i;

  // sink stalls about a quarter of the time
  always @(posedge clk_i) begin
    m_tready <= no_idle || ($urandom_range(99) >= 25);
  end

  // score both streams on the pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) xform.note_pixel(s_tdata);
      if (m_tvalid && m_tready) xform.check_pixel(m_tdata);
    end
  end

  function automatic cmp_pkg::pixel_t rgba(cmp_pkg::chan_t r, cmp_pkg::chan_t g,
                                           cmp_pkg::chan_t b, cmp_pkg::chan_t a);
    return {a, b, g, r};
  endfunction

  // extremes show up often
  function automatic cmp_pkg::chan_t rand_chan();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return cmp_pkg::chan_t'($urandom);
    endcase
  endfunction

  // mostly within +-2.0 so that outputs are not always clamped
  function automatic cmp_pkg::coef_t rand_coef();
    case ($urandom_range(9))
      0:          return '0;
      1:          return 24'sh7FFFFF;
      2:          return 24'sh800000;
      3:          return 24'sh010000;
      4, 5, 6, 7: return cmp_pkg::coef_t'(int'($urandom_range(262144)) - 131072);
      default:    return cmp_pkg::coef_t'($urandom);
    endcase
  endfunction

  function automatic cmp_pkg::coef_mat_t fill_matrix(cmp_pkg::coef_t diag,
                                                     cmp_pkg::coef_t off);
    cmp_pkg::coef_mat_t m;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) m[r][c] = (r == c) ? diag : off;
    return m;
  endfunction

  function automatic cmp_pkg::coef_mat_t rand_matrix();
    cmp_pkg::coef_mat_t m;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) m[r][c] = rand_coef();
    return m;
  endfunction

  // writes all eight registers; bit 48 of the others carries junk
  task automatic write_matrix(input cmp_pkg::coef_mat_t m, input bit premult);
    logic [cmp_pkg::CfgW-1:0] data;
    for (int r = 0; r < 4; r++) begin
      for (int h = 0; h < 2; h++) begin
        data = {1'($urandom_range(1)), m[r][2*h+1], m[r][2*h]};
        if (r == 0 && h == 0) data[cmp_pkg::ModeBit] = premult;
        @(posedge clk_i);
        cfg_we_i    <= 1'b1;
        cfg_idx_i   <= cmp_pkg::reg_idx_e'(r*2 + h);
        cfg_wdata_i <= data;
        xform.write_reg(cmp_pkg::reg_idx_e'(r*2 + h), data);
      end
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // source idles about a quarter of the time
  task automatic send_pixel(input cmp_pkg::pixel_t px);
    while (!no_idle && $urandom_range(99) < 25) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do @(posedge clk_i); while (!s_tready);
  endtask

  // drop valid, wait for every owed pixel, then let the pipe settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (xform.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity and straight clamp out of reset
    send_pixel(rgba(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_pixel(rgba(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_pixel(rgba(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
    send_pixel(rgba(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));
    send_pixel(rgba(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
    send_pixel(rgba(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
    drain();

    // largest positive coefficients: sums run past the top
    write_matrix(fill_matrix(24'sh7FFFFF, 24'sh7FFFFF), 1'b0);
    send_pixel(rgba(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_pixel(rgba(16'h0001, 16'h0001, 16'h0001, 16'h0001));
    send_pixel(rgba(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    drain();

    // most negative coefficients, premultiplied: sums fall below zero
    write_matrix(fill_matrix(24'sh800000, 24'sh800000), 1'b1);
    send_pixel(rgba(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_pixel(rgba(16'h0001, 16'h0001, 16'h0001, 16'h0001));
    send_pixel(rgba(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    drain();

    // off-diagonal of minus one lsb: each nonzero term floors to -1
    write_matrix(fill_matrix(24'sh010000, 24'shFFFFFF), 1'b0);
    send_pixel(rgba(16'h1000, 16'h0001, 16'h0001, 16'h0001));
    send_pixel(rgba(16'h0000, 16'h0001, 16'h0001, 16'h0001));
    send_pixel(rgba(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    drain();

    // identity, premultiplied: colors above alpha are cut to alpha
    write_matrix(fill_matrix(24'sh010000, 24'sh000000), 1'b1);
    send_pixel(rgba(16'hFFFF, 16'h8000, 16'h0100, 16'h4000));
    send_pixel(rgba(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000));
    drain();

    // random matrices and clamp modes; one phase runs without idling
    for (int p = 0; p < RandPhases; p++) begin
      no_idle <= (p == 3);
      write_matrix(rand_matrix(), 1'($urandom_range(1)));
      repeat (PhaseBeats) send_pixel(rgba(rand_chan(), rand_chan(), rand_chan(), rand_chan()));
      drain();
    end

    if (xform.mismatch_count == 0 && xform.pending() == 0) begin
      $display("PASS color_matrix_pixel_top");
    end else begin
      $display("FAIL color_matrix_pixel_top");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("FAIL color_matrix_pixel_top");
    $finish;
  end

endmodule
